### rtl/core/bia_pkg.sv
// bia_pkg: shared types and constants for the bitmap id allocator.
// Holds the request/result payload structs, status codes and FSM states.
// No dependencies.
package bia_pkg;

	localparam int NUM_IDS_DEF = 1024;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = 6;
	localparam int ID_IN_W     = 10;
	localparam int CNT_OUT_W   = 11;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_DBL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t               kind;
		logic [ID_IN_W-1:0]  id;
	} req_t;

	typedef struct packed {
		logic [ID_IN_W-1:0]   id_res;
		status_t              status;
		logic [CNT_OUT_W-1:0] free_count;
	} res_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} hit_t;

endpackage

### rtl/core/bitmap_id_allocator.sv
// bitmap_id_allocator: next-fit id allocator, top level.
// Depends on bia_pkg, bia_ram, bia_scan.
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low. req.kind selects allocate or free; req.id is the id to free.
//   Result channel: done is high for exactly one cycle with res valid. The
//   receiver cannot stall; every command yields exactly one result.
// Command handling:
//   Free of an id in range: the bitmap word is read, then checked and
//   updated in S_FREE; the result is registered from there.
//   Free out of range, or allocate with no free ids: result in the next cycle.
//   Allocate: the scan reads 64-bit bitmap words from the start word up to
//   the word holding the id found (at most ceil(NUM_IDS/64) words, 16 by
//   default). The bitmap RAM delivers one word per cycle on its registered
//   read port; the scan reads the next word each cycle while checking the
//   current one. busy is high while a command is in progress and falls as
//   done rises, so the next command can be taken in the done cycle.
// Reset:
//   arst_n clears control state, then the bitmap RAM is cleared one word per
//   cycle, ceil(NUM_IDS/64) words in all, with busy high. The free count resets to
//   NUM_IDS and the first allocation searches from id 0.
module bitmap_id_allocator #(
	parameter int NUM_IDS = bia_pkg::NUM_IDS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bia_pkg::req_t req,
	output logic          done,
	output bia_pkg::res_t res
);

	import bia_pkg::*;

	localparam int MAP_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
	localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int ID_W      = $clog2(NUM_IDS);
	localparam int CNT_W     = $clog2(NUM_IDS + 1);
	localparam logic [WIDX_W-1:0] LAST_W = WIDX_W'(MAP_WORDS - 1);

	state_t              state_q, state_d;
	logic [WIDX_W-1:0]   clr_q, clr_d;
	logic [ID_W-1:0]     start_q, start_d;
	logic [CNT_W-1:0]    free_q, free_d;
	logic [WIDX_W-1:0]   chk_w_s1, chk_w_d;
	logic                first_s1, first_d;
	logic [ID_W-1:0]     fid_q, fid_d;
	logic                done_q, done_d;
	res_t                res_q, res_d;

	logic                ram_we;
	logic [WIDX_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [WIDX_W-1:0]   ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;
	hit_t                hit;
	logic [ID_W-1:0]     n_c;
	logic                in_range;

	bia_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_WORDS),
		.AW   (WIDX_W)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bia_scan #(
		.NUM_IDS(NUM_IDS)
	) u_scan (
		.word  (ram_rdata),
		.first (first_s1),
		.lo_bit(start_q[BIT_W-1:0]),
		.last  (chk_w_s1 == LAST_W),
		.hit   (hit)
	);

	assign n_c      = ID_W'({chk_w_s1, hit.idx});
	assign in_range = 32'(req.id) < NUM_IDS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			start_q <= '0;
			free_q  <= CNT_W'(NUM_IDS);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			start_q <= start_d;
			free_q  <= free_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		chk_w_s1 <= chk_w_d;
		first_s1 <= first_d;
		fid_q    <= fid_d;
		res_q    <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		start_d   = start_q;
		free_d    = free_q;
		chk_w_d   = chk_w_s1;
		first_d   = first_s1;
		fid_d     = fid_q;
		done_d    = 1'b0;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = WIDX_W'(start_q >> BIT_W);

		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_W) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (req.kind == KIND_ALLOC) begin
						if (free_q == '0) begin
							done_d            = 1'b1;
							res_d.id_res      = '0;
							res_d.status      = ST_NONE;
							res_d.free_count  = CNT_OUT_W'(free_q);
						end else begin
							state_d = S_SCAN;
							chk_w_d = WIDX_W'(start_q >> BIT_W);
							first_d = 1'b1;
						end
					end else begin
						if (in_range) begin
							ram_raddr = WIDX_W'(ID_W'(req.id) >> BIT_W);
							fid_d     = ID_W'(req.id);
							state_d   = S_FREE;
						end else begin
							done_d            = 1'b1;
							res_d.id_res      = req.id;
							res_d.status      = ST_DBL;
							res_d.free_count  = CNT_OUT_W'(free_q);
						end
					end
				end
			end
			S_SCAN: begin
				ram_raddr = chk_w_s1 + 1'b1;
				if (hit.found) begin
					ram_we           = 1'b1;
					ram_waddr        = chk_w_s1;
					ram_wdata        = ram_rdata | (64'd1 << hit.idx);
					free_d           = free_q - 1'b1;
					if (({1'b0, n_c} + 1'b1) >= (ID_W + 1)'(NUM_IDS)) begin
						start_d = '0;
					end else begin
						start_d = n_c + 1'b1;
					end
					done_d           = 1'b1;
					res_d.id_res     = ID_IN_W'(n_c);
					res_d.status     = ST_OK;
					res_d.free_count = CNT_OUT_W'(free_q - 1'b1);
					state_d          = S_IDLE;
				end else if (chk_w_s1 == LAST_W) begin
					done_d           = 1'b1;
					res_d.id_res     = '0;
					res_d.status     = ST_NONE;
					res_d.free_count = CNT_OUT_W'(free_q);
					state_d          = S_IDLE;
				end else begin
					chk_w_d = chk_w_s1 + 1'b1;
					first_d = 1'b0;
				end
			end
			S_FREE: begin
				ram_waddr    = WIDX_W'(fid_q >> BIT_W);
				done_d       = 1'b1;
				res_d.id_res = ID_IN_W'(fid_q);
				if (ram_rdata[fid_q[BIT_W-1:0]]) begin
					ram_we           = 1'b1;
					ram_wdata        = ram_rdata & ~(64'd1 << fid_q[BIT_W-1:0]);
					free_d           = free_q + 1'b1;
					res_d.status     = ST_OK;
					res_d.free_count = CNT_OUT_W'(free_q + 1'b1);
				end else begin
					res_d.status     = ST_DBL;
					res_d.free_count = CNT_OUT_W'(free_q);
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

### rtl/core/bia_ram.sv
// bia_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
module bia_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/bia_scan.sv
// bia_scan: finds the lowest clear bit of one bitmap word within the search window.
// Depends on bia_pkg.
module bia_scan #(
	parameter int NUM_IDS = bia_pkg::NUM_IDS_DEF
) (
	input  logic [bia_pkg::WORD_W-1:0] word,
	input  logic                       first,
	input  logic [bia_pkg::BIT_W-1:0]  lo_bit,
	input  logic                       last,
	output bia_pkg::hit_t              hit
);

	import bia_pkg::*;

	localparam int REM = NUM_IDS % WORD_W;
	localparam logic [WORD_W-1:0] TOP_MASK =
		(REM == 0) ? {WORD_W{1'b1}} : ((64'd1 << REM) - 64'd1);

	logic [WORD_W-1:0] free_v;

	always_comb begin
		free_v = ~word;
		if (first) begin
			free_v = free_v & ({WORD_W{1'b1}} << lo_bit);
		end
		if (last) begin
			free_v = free_v & TOP_MASK;
		end
		hit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_v[i]) begin
				hit.found = 1'b1;
				hit.idx   = BIT_W'(i);
			end
		end
	end

endmodule

### rtl/core/bia_checker.sv
// bia_checker: port-level checks on command/result ordering of the allocator.
// Depends on bia_pkg; bound to bitmap_id_allocator below.
module bia_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input bia_pkg::req_t req,
	input logic          done,
	input bia_pkg::res_t res
);

	import bia_pkg::*;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status == ST_NONE |-> res.id_res == '0)
		else $error("failed allocation returned nonzero id");

	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $past(busy))
		else $error("result without a pending command");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor answered");

	a_free_echo: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == KIND_FREE |=> busy || res.id_res == $past(req.id))
		else $error("free result does not echo the id");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.res   (res)
);
